[hdl/bpa_pkg.sv]
package bpa_pkg;

    localparam int ORD_W  = 4;
    localparam int PIDX_W = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOBLK = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic              op;
        logic [ORD_W-1:0]  order;
        logic [PIDX_W-1:0] page_index;
    } t_cmd;

    typedef struct packed {
        logic [1:0]        status;
        logic [PIDX_W-1:0] page_index_res;
    } t_result;

    typedef struct packed {
        logic             free;
        logic [ORD_W-1:0] order;
    } t_flag;

    typedef struct packed {
        logic flag;
        logic next;
        logic prev;
    } t_mem_we;

endpackage

[hdl/bpa_page_mem.sv]
module bpa_page_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int NW    = 11
) (
    input  logic             i_clk,
    input  bpa_pkg::t_mem_we i_we,
    input  logic [AW-1:0]    i_flag_wa,
    input  bpa_pkg::t_flag   i_flag_wd,
    input  logic [AW-1:0]    i_next_wa,
    input  logic [NW-1:0]    i_next_wd,
    input  logic [AW-1:0]    i_prev_wa,
    input  logic [NW-1:0]    i_prev_wd,
    input  logic [AW-1:0]    i_ra,
    output bpa_pkg::t_flag   o_flag,
    output logic [NW-1:0]    o_next,
    output logic [NW-1:0]    o_prev
);

    bpa_pkg::t_flag  flag_mem [DEPTH];
    logic [NW-1:0]   next_mem [DEPTH];
    logic [NW-1:0]   prev_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.flag) begin
            flag_mem[i_flag_wa] <= i_flag_wd;
        end
        o_flag <= flag_mem[i_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.next) begin
            next_mem[i_next_wa] <= i_next_wd;
        end
        o_next <= next_mem[i_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.prev) begin
            prev_mem[i_prev_wa] <= i_prev_wd;
        end
        o_prev <= prev_mem[i_ra];
    end

endmodule

[hdl/buddy_page_allocator.sv]
// Binary buddy page allocator. Pulse i_start with a command while o_busy is low;
// exactly one result follows on o_result, marked by a one-cycle o_valid strobe
// that cannot be held off. Per-page state (free mark, order, list links) lives in
// synchronous memories with a registered read; free-list heads sit in flip-flops.
// After reset a clearing sweep over all NUM_PAGES pages runs with o_busy high.
// A range error is reported from idle. An allocate searches upward from the
// requested order and splits level by level; a free merges level by level, each
// step a read-modify-write sequence over the page memory's single read port.
module buddy_page_allocator #(
    parameter int ORDERS    = 11,
    parameter int NUM_PAGES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  bpa_pkg::t_cmd    i_cmd,
    output logic             o_busy,
    output logic             o_valid,
    output bpa_pkg::t_result o_result
);

    localparam int AW = $clog2(NUM_PAGES);
    localparam int NW = $clog2(NUM_PAGES + 1);
    localparam int OW = $clog2(ORDERS);
    localparam int KW = $clog2(ORDERS + 1);
    localparam int SW = ((NW > ORDERS) ? NW : ORDERS) + 1;
    localparam logic [NW-1:0] NONE = NW'(NUM_PAGES);
    localparam logic [bpa_pkg::ORD_W-1:0] TOP = bpa_pkg::ORD_W'(ORDERS - 1);

    typedef enum logic [14:0] {
        S_CLR     = 15'h0001,
        S_IDLE    = 15'h0002,
        S_SRCH    = 15'h0004,
        S_AL_RD   = 15'h0008,
        S_AL_TK   = 15'h0010,
        S_SPLIT   = 15'h0020,
        S_FR_RD   = 15'h0040,
        S_FR_CHK  = 15'h0080,
        S_MG_TEST = 15'h0100,
        S_MG_RD   = 15'h0200,
        S_MG_CHK  = 15'h0400,
        S_PO_RD   = 15'h0800,
        S_PO_CHK  = 15'h1000,
        S_PO_W1   = 15'h2000,
        S_PO_W2   = 15'h4000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [NW-1:0] r_head [ORDERS];
    logic [NW-1:0] n_head [ORDERS];
    logic r_vld, n_vld;

    logic [KW-1:0] r_k, n_k;
    logic [NW-1:0] r_p, n_p;
    logic [NW-1:0] r_a, n_a;
    logic [NW-1:0] r_h, n_h;
    logic [bpa_pkg::ORD_W-1:0] r_o, n_o;
    logic [bpa_pkg::ORD_W-1:0] r_po, n_po;
    logic r_ret, n_ret;
    logic [1:0] r_status, n_status;
    logic [bpa_pkg::PIDX_W-1:0] r_res, n_res;

    bpa_pkg::t_mem_we we;
    logic [AW-1:0]  flag_wa, next_wa, prev_wa;
    bpa_pkg::t_flag flag_wd, tk_flag, w_flag;
    logic [NW-1:0]  next_wd, prev_wd, w_next, w_prev;
    logic           tk_en;
    logic [SW-1:0]  w_half, w_bud, w_pfree;

    bpa_page_mem #(
        .DEPTH(NUM_PAGES),
        .AW   (AW),
        .NW   (NW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_flag_wa(flag_wa),
        .i_flag_wd(flag_wd),
        .i_next_wa(next_wa),
        .i_next_wd(next_wd),
        .i_prev_wa(prev_wa),
        .i_prev_wd(prev_wd),
        .i_ra     (r_a[AW-1:0]),
        .o_flag   (w_flag),
        .o_next   (w_next),
        .o_prev   (w_prev)
    );

    assign w_half  = SW'(r_p) + (SW'(1) << (r_k - KW'(1)));
    assign w_bud   = SW'(r_p) ^ (SW'(1) << r_o);
    assign w_pfree = SW'(i_cmd.page_index) & ~((SW'(1) << i_cmd.order) - SW'(1));

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_head   = r_head;
        n_vld    = 1'b0;
        n_k      = r_k;
        n_p      = r_p;
        n_a      = r_a;
        n_h      = r_h;
        n_o      = r_o;
        n_po     = r_po;
        n_ret    = r_ret;
        n_status = r_status;
        n_res    = r_res;
        we       = '0;
        flag_wa  = r_a[AW-1:0];
        flag_wd  = '0;
        next_wa  = '0;
        next_wd  = '0;
        prev_wa  = '0;
        prev_wd  = '0;
        tk_en    = 1'b0;
        tk_flag  = '0;

        case (r_state)
            S_CLR: begin
                we      = '{flag: 1'b1, next: 1'b1, prev: 1'b1};
                flag_wa = r_clr;
                flag_wd = (r_clr == '0) ? bpa_pkg::t_flag'{free: 1'b1, order: TOP} : '0;
                next_wa = r_clr;
                next_wd = NONE;
                prev_wa = r_clr;
                prev_wd = NONE;
                if (r_clr == AW'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (int'(i_cmd.order) >= ORDERS) begin
                        n_vld    = 1'b1;
                        n_status = bpa_pkg::ST_RANGE;
                        n_res    = '0;
                    end else if (i_cmd.op == bpa_pkg::OP_ALLOC) begin
                        n_k     = KW'(i_cmd.order);
                        n_o     = i_cmd.order;
                        n_state = S_SRCH;
                    end else if (int'(i_cmd.page_index) >= NUM_PAGES) begin
                        n_vld    = 1'b1;
                        n_status = bpa_pkg::ST_RANGE;
                        n_res    = '0;
                    end else begin
                        n_p     = NW'(w_pfree);
                        n_a     = NW'(w_pfree);
                        n_o     = i_cmd.order;
                        n_state = S_FR_RD;
                    end
                end
            end
            S_SRCH: begin
                if (int'(r_k) >= ORDERS) begin
                    n_vld    = 1'b1;
                    n_status = bpa_pkg::ST_NOBLK;
                    n_res    = '0;
                    n_state  = S_IDLE;
                end else if (r_head[r_k[OW-1:0]] == NONE) begin
                    n_k = r_k + KW'(1);
                end else begin
                    n_p     = r_head[r_k[OW-1:0]];
                    n_a     = r_head[r_k[OW-1:0]];
                    n_state = S_AL_RD;
                end
            end
            S_AL_RD: begin
                n_state = S_AL_TK;
            end
            S_AL_TK: begin
                tk_en   = 1'b1;
                tk_flag = '{free: 1'b0, order: r_o};
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (int'(r_k) > int'(r_o)) begin
                    n_k = r_k - KW'(1);
                    if (w_half < SW'(NUM_PAGES)) begin
                        n_a     = NW'(w_half);
                        n_po    = bpa_pkg::ORD_W'(r_k - KW'(1));
                        n_ret   = 1'b1;
                        n_state = S_PO_RD;
                    end
                end else begin
                    n_vld    = 1'b1;
                    n_status = bpa_pkg::ST_OK;
                    n_res    = bpa_pkg::PIDX_W'(r_p);
                    n_state  = S_IDLE;
                end
            end
            S_FR_RD: begin
                n_state = S_FR_CHK;
            end
            S_FR_CHK: begin
                if (w_flag.free) begin
                    n_vld    = 1'b1;
                    n_status = bpa_pkg::ST_OK;
                    n_res    = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_MG_TEST;
                end
            end
            S_MG_TEST: begin
                if (int'(r_o) < ORDERS - 1 && w_bud < SW'(NUM_PAGES)) begin
                    n_a     = NW'(w_bud);
                    n_state = S_MG_RD;
                end else begin
                    n_a     = r_p;
                    n_po    = r_o;
                    n_ret   = 1'b0;
                    n_state = S_PO_RD;
                end
            end
            S_MG_RD: begin
                n_state = S_MG_CHK;
            end
            S_MG_CHK: begin
                if (w_flag.free && w_flag.order == r_o) begin
                    tk_en   = 1'b1;
                    tk_flag = '0;
                    if (r_a < r_p) begin
                        n_p = r_a;
                    end
                    n_o     = r_o + bpa_pkg::ORD_W'(1);
                    n_state = S_MG_TEST;
                end else begin
                    n_a     = r_p;
                    n_po    = r_o;
                    n_ret   = 1'b0;
                    n_state = S_PO_RD;
                end
            end
            S_PO_RD: begin
                n_state = S_PO_CHK;
            end
            S_PO_CHK: begin
                if (w_flag.free && int'(w_flag.order) < ORDERS) begin
                    tk_en   = 1'b1;
                    tk_flag = '{free: 1'b0, order: w_flag.order};
                end
                n_state = S_PO_W1;
            end
            S_PO_W1: begin
                n_h     = r_head[r_po[OW-1:0]];
                we      = '{flag: 1'b1, next: 1'b1, prev: 1'b1};
                flag_wa = r_a[AW-1:0];
                flag_wd = '{free: 1'b1, order: r_po};
                next_wa = r_a[AW-1:0];
                next_wd = r_head[r_po[OW-1:0]];
                prev_wa = r_a[AW-1:0];
                prev_wd = NONE;
                n_head[r_po[OW-1:0]] = r_a;
                n_state = S_PO_W2;
            end
            S_PO_W2: begin
                if (r_h != NONE) begin
                    we.prev = 1'b1;
                    prev_wa = r_h[AW-1:0];
                    prev_wd = r_a;
                end
                if (r_ret) begin
                    n_state = S_SPLIT;
                end else begin
                    n_vld    = 1'b1;
                    n_status = bpa_pkg::ST_OK;
                    n_res    = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (tk_en) begin
            we.flag = 1'b1;
            flag_wa = r_a[AW-1:0];
            flag_wd = tk_flag;
            if (w_prev != NONE) begin
                we.next = 1'b1;
                next_wa = w_prev[AW-1:0];
                next_wd = w_next;
            end else begin
                n_head[w_flag.order[OW-1:0]] = w_next;
            end
            if (w_next != NONE) begin
                we.prev = 1'b1;
                prev_wa = w_next[AW-1:0];
                prev_wd = w_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_vld   <= 1'b0;
            for (int i = 0; i < ORDERS; i++) begin
                r_head[i] <= (i == ORDERS - 1) ? '0 : NONE;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_vld   <= n_vld;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_p      <= n_p;
        r_a      <= n_a;
        r_h      <= n_h;
        r_o      <= n_o;
        r_po     <= n_po;
        r_ret    <= n_ret;
        r_status <= n_status;
        r_res    <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_vld;
    assign o_result = '{status: r_status, page_index_res: r_res};

`ifndef NO_ASSERTIONS
    a_idle_on_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe while busy");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != bpa_pkg::ST_OK) |-> (o_result.page_index_res == '0))
        else $error("failed request returned a page");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.status == bpa_pkg::ST_OK || o_result.status == bpa_pkg::ST_NOBLK
                     || o_result.status == bpa_pkg::ST_RANGE))
        else $error("undefined status code");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_valid))
        else $error("accepted transfer dropped");
`endif

endmodule
